>>> hw/rtl/ipv4fhb_pkg.sv
// shared types and constants of the ipv4 fragment header builder
// no dependencies; imported by every module of the block
`default_nettype none

package ipv4fhb_pkg;

  // fixed header constants
  localparam int unsigned IP_HDR_BYTES = 20;
  localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
  localparam logic [7:0]  TTL_RESET    = 8'd64;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL        = 2'd1;

  // request queue geometry
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  // widths of the checksum partial sums
  localparam int unsigned BASE_SUM_W = 19;
  localparam int unsigned FULL_SUM_W = 20;

  // one classified request
  typedef struct packed {
    logic [15:0]           payload_len;
    logic [BASE_SUM_W-1:0] base_sum;
  } req_t;

  // push from front part into the queue
  typedef struct packed {
    logic valid;
    req_t req;
  } push_t;

endpackage

`default_nettype wire

>>> hw/rtl/ipv4fhb_front.sv
// front part: configuration registers, request accept, fixed checksum words
// depends on ipv4fhb_pkg
`default_nettype none

module ipv4fhb_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  input  wire logic [ipv4fhb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                       cfg_data,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [15:0]                       payload_len,
  input  wire logic [7:0]                        protocol_num,
  input  wire logic [31:0]                       dest_address,
  input  wire logic                              queue_full,
  output      ipv4fhb_pkg::push_t                push
);
  import ipv4fhb_pkg::*;

  logic [31:0] local_address;
  logic [7:0]  time_to_live;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
      time_to_live  <= TTL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOCAL_ADDR: local_address <= cfg_data;
        CFG_TTL:        time_to_live  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // accept handshake, and sum of the header words that stay the same over all fragments
  assign in_ready        = !queue_full;
  assign push.valid      = in_valid && !queue_full;
  assign push.req.payload_len = payload_len;
  assign push.req.base_sum =
      BASE_SUM_W'(VER_IHL_TOS)
    + BASE_SUM_W'({time_to_live, protocol_num})
    + BASE_SUM_W'(local_address[31:16])
    + BASE_SUM_W'(local_address[15:0])
    + BASE_SUM_W'(dest_address[31:16])
    + BASE_SUM_W'(dest_address[15:0]);

endmodule

`default_nettype wire

>>> hw/rtl/ipv4fhb_queue.sv
// two-entry request queue between front and back parts
// depends on ipv4fhb_pkg
`default_nettype none

module ipv4fhb_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ipv4fhb_pkg::push_t  push,
  output      logic                full,
  output      logic                not_empty,
  output      ipv4fhb_pkg::req_t   head,
  input  wire logic                pop
);
  import ipv4fhb_pkg::*;

  req_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.req;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop)        rd_ptr <= rd_ptr + 1'b1;
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // no pop from an empty queue, no push into a full one
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("queue pop while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full) else $error("queue push while full");

endmodule

`default_nettype wire

>>> hw/rtl/ipv4fhb_back.sv
// back part: fragment sequencer, per-fragment checksum and output register
// depends on ipv4fhb_pkg
`default_nettype none

module ipv4fhb_back #(
  parameter int unsigned LINK_MTU = 1500
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire ipv4fhb_pkg::req_t  req,
  output      logic               req_pop,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [15:0]        packet_ident,
  output      logic [12:0]        frag_offset,
  output      logic               more_fragments,
  output      logic [10:0]        total_length,
  output      logic [15:0]        header_checksum
);
  import ipv4fhb_pkg::*;

  localparam int unsigned LimitLen  = LINK_MTU - IP_HDR_BYTES;
  localparam int unsigned FragStep  = (LimitLen / 8) * 8;
  localparam logic [15:0] LimitW    = 16'(LimitLen);
  localparam logic [15:0] StepW     = 16'(FragStep);
  localparam logic [12:0] StepUnits = 13'(FragStep / 8);
  localparam logic [15:0] FullTlen  = 16'(FragStep + IP_HDR_BYTES);
  localparam logic [15:0] HdrLen    = 16'(IP_HDR_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_FOLD, S_WAIT} state_t;

  state_t                state;
  logic [15:0]           remaining;
  logic [12:0]           offset;
  logic [BASE_SUM_W-1:0] base_sum;
  logic [15:0]           ident;
  logic                  mf;
  logic [10:0]           tlen;
  logic [FULL_SUM_W-1:0] sum;

  logic                  mf_c;
  logic [15:0]           tlen_c;
  logic [16:0]           fold1;
  logic [15:0]           fold2;

  // split decision, length of the current fragment and checksum fold
  always_comb begin
    mf_c   = remaining > LimitW;
    tlen_c = mf_c ? FullTlen : remaining + HdrLen;
    fold1  = {1'b0, sum[15:0]} + 17'(sum[FULL_SUM_W-1:16]);
    fold2  = fold1[15:0] + 16'(fold1[16]);
  end

  assign req_pop   = (state == S_WAIT) && out_ready && !mf;
  assign out_valid = (state == S_WAIT);

  // sequencer with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ident <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            remaining <= req.payload_len;
            base_sum  <= req.base_sum;
            offset    <= '0;
            state     <= S_SUM;
          end
        end
        S_SUM: begin
          mf    <= mf_c;
          tlen  <= tlen_c[10:0];
          sum   <= FULL_SUM_W'(base_sum) + FULL_SUM_W'(tlen_c) + FULL_SUM_W'(ident)
                 + FULL_SUM_W'({2'b00, mf_c, offset});
          state <= S_FOLD;
        end
        S_FOLD: begin
          packet_ident    <= ident;
          frag_offset     <= offset;
          more_fragments  <= mf;
          total_length    <= tlen;
          header_checksum <= ~fold2;
          state           <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            if (mf) begin
              remaining <= remaining - StepW;
              offset    <= offset + StepUnits;
              state     <= S_SUM;
            end else begin
              ident <= ident + 16'd1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a fragment with more following always carries a full step of payload
  a_full_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && more_fragments) |-> total_length == FullTlen[10:0])
    else $error("non-last fragment with short length");
  // identifier moves on only after the last fragment is taken
  a_ident_step: assert property (@(posedge clk) disable iff (rst)
    req_pop |=> ident == $past(ident) + 16'd1)
    else $error("identifier not advanced after last fragment");

endmodule

`default_nettype wire

>>> hw/rtl/ipv4_fragment_header_builder_unit.sv
// Send request in, one IPv4 header record per fragment out. A request is
// classified by the front part (fixed checksum words summed) and parked in a
// two-entry queue. The request being worked on stays at the queue head until
// its last fragment is taken, so one further request is taken while the back
// part works. The back part loads the request, then takes each fragment
// through the steps sum, fold and present, waiting in present until the output
// is taken; this pace is set by the single checksum adder and fold path of the
// fragment sequencer. The payload of every fragment but the last is
// (LINK_MTU - 20) rounded down to a multiple of 8. Configuration writes are
// taken every cycle and apply to requests accepted afterwards.
// depends on ipv4fhb_pkg, ipv4fhb_front, ipv4fhb_queue, ipv4fhb_back
`default_nettype none

module ipv4_fragment_header_builder_unit #(
  parameter int unsigned LINK_MTU = 1500
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [ipv4fhb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                       cfg_data,
  // requests
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // payload_len[15:0], protocol_num[23:16], dest_address[55:24]
  input  wire logic [55:0]                       s_axis_tdata,
  // header records
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // packet_ident[15:0], frag_offset[28:16], total_length[39:29],
  // header_checksum[55:40]
  output      logic [55:0]                       m_axis_tdata,
  // high on the last fragment (more-fragments flag clear)
  output      logic                              m_axis_tlast
);
  import ipv4fhb_pkg::*;

  push_t       push;
  req_t        head;
  logic        queue_full;
  logic        queue_not_empty;
  logic        queue_pop;
  logic [15:0] packet_ident;
  logic [12:0] frag_offset;
  logic        more_fragments;
  logic [10:0] total_length;
  logic [15:0] header_checksum;

  assign cfg_ready = 1'b1;

  ipv4fhb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .payload_len  (s_axis_tdata[15:0]),
    .protocol_num (s_axis_tdata[23:16]),
    .dest_address (s_axis_tdata[55:24]),
    .queue_full   (queue_full),
    .push         (push)
  );

  ipv4fhb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head),
    .pop       (queue_pop)
  );

  ipv4fhb_back #(
    .LINK_MTU (LINK_MTU)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (queue_not_empty),
    .req             (head),
    .req_pop         (queue_pop),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .packet_ident    (packet_ident),
    .frag_offset     (frag_offset),
    .more_fragments  (more_fragments),
    .total_length    (total_length),
    .header_checksum (header_checksum)
  );

  // pack the record
  assign m_axis_tdata = {header_checksum, total_length, frag_offset, packet_ident};
  assign m_axis_tlast = !more_fragments;

endmodule

`default_nettype wire
